/* rtl/ssos_pkg.sv */
// Shared types and constants for the segment/sphere occlusion summer.
// Used by ssos_arith and segment_sphere_occlusion_sum; no dependencies.
package ssos_pkg;

   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_REMOVE     = 2'd1,
      OP_SET_RADIUS = 2'd2,
      OP_QUERY      = 2'd3
   } ssos_op_type;

   typedef struct packed {
      ssos_op_type        operation;
      logic [3:0]         slot;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] bz;
      logic [11:0]        radius;
      logic               is_smoke;
      logic [11:0]        bloat;
   } ssos_req_type;

   typedef struct packed {
      logic        blocked;
      logic [19:0] covered_length;
   } ssos_rsp_type;

   // one table entry as stored in RAM
   typedef struct packed {
      logic               smoke;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
      logic [11:0]        radius;
   } ssos_entry_type;

   typedef enum logic [1:0] {
      AOP_MUL  = 2'd0,   // signed 25x25 product
      AOP_PROJ = 2'd1,   // floor(num^2 * 2^16 / den)
      AOP_SQRT = 2'd2    // floor square root
   } ssos_aop_type;

   typedef struct packed {
      logic               start;
      ssos_aop_type       op;
      logic signed [24:0] ma;
      logic signed [24:0] mb;
      logic [33:0]        num;
      logic [33:0]        den;
      logic [49:0]        rad;
   } ssos_acmd_type;

   typedef struct packed {
      logic        done;
      logic [49:0] value;
   } ssos_ares_type;

   typedef enum logic [3:0] {
      A_IDLE, A_MUL, A_SQ0, A_SQ1, A_SQ2, A_SQ3, A_DIV, A_SQRT, A_DONE
   } ssos_astate_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SETR, S_GO, S_WAIT, S_ENT_RD, S_ENT_LATCH,
      S_CLASS, S_CHECK, S_ADD, S_DONE
   } ssos_state_type;

   typedef enum logic [3:0] {
      J_L2, J_SLEN, J_FSQ, J_TSQ, J_DT, J_DV, J_RB, J_R2,
      J_Q1, J_Q2, J_OFFF, J_OFFT, J_HALF
   } ssos_job_type;

   localparam logic [5:0]  DIV_STEPS  = 6'd50;
   localparam logic [5:0]  SQRT_STEPS = 6'd25;
   localparam logic [1:0]  LANE_LAST  = 2'd2;
   localparam logic [15:0] THRESHOLD_RESET = 16'd108;

endpackage

/* rtl/ssos_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/ssos_arith.sv */
// Shared arithmetic unit: 25x25 multiply, squared-projection divide
// (one quotient bit a cycle) and floor square root (two radicand bits a cycle).
// Depends on ssos_pkg.
module ssos_arith
   import ssos_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ssos_acmd_type cmd,
   output ssos_ares_type res
);

   ssos_astate_type state_ff, state_in;

   ssos_aop_type       op_ff;
   logic signed [24:0] ma_ff, mb_ff;
   logic [33:0]        num_ff, den_ff;
   logic signed [49:0] prod_ff;
   logic [67:0]        acc_ff;
   logic [33:0]        rem_ff;
   logic [49:0]        sh_ff, q_ff;
   logic [49:0]        sv_ff, sres_ff, sbit_ff;
   logic [5:0]         cnt_ff;

   logic signed [24:0] mul_a, mul_b, nh, nl;
   logic signed [49:0] mul_p;
   logic [67:0]        full;
   logic [34:0]        trial, trial_sub;
   logic               div_ge, sq_ge;
   logic [49:0]        sq_sum;

   assign nh = $signed({8'd0, num_ff[33:17]});
   assign nl = $signed({8'd0, num_ff[16:0]});

   always_comb begin
      mul_a = ma_ff;
      mul_b = mb_ff;
      unique case (state_ff)
         A_SQ0: begin mul_a = nh; mul_b = nh; end
         A_SQ1: begin mul_a = nh; mul_b = nl; end
         A_SQ2: begin mul_a = nl; mul_b = nl; end
         default: ;
      endcase
   end

   assign mul_p     = mul_a * mul_b;
   assign full      = acc_ff + {34'd0, prod_ff[33:0]};
   assign trial     = {rem_ff, sh_ff[49]};
   assign div_ge    = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};
   assign sq_sum    = sres_ff + sbit_ff;
   assign sq_ge     = sv_ff >= sq_sum;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               unique case (cmd.op)
                  AOP_MUL:  state_in = A_MUL;
                  AOP_PROJ: state_in = A_SQ0;
                  AOP_SQRT: state_in = A_SQRT;
                  default:  state_in = A_IDLE;
               endcase
            end
         end
         A_MUL:  state_in = A_DONE;
         A_SQ0:  state_in = A_SQ1;
         A_SQ1:  state_in = A_SQ2;
         A_SQ2:  state_in = A_SQ3;
         A_SQ3:  state_in = A_DIV;
         A_DIV:  if (cnt_ff == 6'd1) state_in = A_DONE;
         A_SQRT: if (cnt_ff == 6'd1) state_in = A_DONE;
         A_DONE: state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      res.done  = 1'b0;
      res.value = q_ff;
      unique case (state_ff)
         A_DONE: begin
            res.done = 1'b1;
            case (op_ff)
               AOP_MUL:  res.value = prod_ff;
               AOP_SQRT: res.value = {25'd0, sres_ff[24:0]};
               default:  res.value = q_ff;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end

      unique case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               op_ff   <= cmd.op;
               ma_ff   <= cmd.ma;
               mb_ff   <= cmd.mb;
               num_ff  <= cmd.num;
               den_ff  <= cmd.den;
               sv_ff   <= cmd.rad;
               sres_ff <= '0;
               sbit_ff <= 50'd1 << 48;
               cnt_ff  <= SQRT_STEPS;
            end
         end
         A_MUL, A_SQ0: prod_ff <= mul_p;
         A_SQ1: begin
            acc_ff  <= {prod_ff[33:0], 34'd0};
            prod_ff <= mul_p;
         end
         A_SQ2: begin
            acc_ff  <= acc_ff + {16'd0, prod_ff[33:0], 18'd0};
            prod_ff <= mul_p;
         end
         A_SQ3: begin
            // dividend is full << 16; its top part is already below den
            rem_ff <= full[67:34];
            sh_ff  <= {full[33:0], 16'd0};
            q_ff   <= '0;
            cnt_ff <= DIV_STEPS;
         end
         A_DIV: begin
            rem_ff <= div_ge ? trial_sub[33:0] : trial[33:0];
            q_ff   <= {q_ff[48:0], div_ge};
            sh_ff  <= {sh_ff[48:0], 1'b0};
            cnt_ff <= cnt_ff - 6'd1;
         end
         A_SQRT: begin
            sv_ff   <= sq_ge ? sv_ff - sq_sum : sv_ff;
            sres_ff <= sq_ge ? (sres_ff >> 1) + sbit_ff : sres_ff >> 1;
            sbit_ff <= sbit_ff >> 2;
            cnt_ff  <= cnt_ff - 6'd1;
         end
         default: ;
      endcase
   end

endmodule

/* rtl/segment_sphere_occlusion_sum.sv */
// Top level: sphere table in RAM, query sequencer and length accumulator.
// Depends on ssos_pkg, ssos_ram and ssos_arith.
//
//  channel  ports                          beat taken when
//  request  start, busy, req_data          start && !busy
//  result   rsp_strobe, rsp_data           rsp_strobe (one cycle, no stall)
//  config   csr_valid, csr_ready, csr_data csr_valid && csr_ready
//
// Insert and remove act in S_IDLE; set radius reads RAM, then writes back (S_SETR).
// A query first sizes the segment, then walks every slot: empty slots and non-smoke
// entries are passed over, and each smoke entry uses the shared arith unit (up to two
// 50-step divides and up to three 25-step square roots); S_DONE finishes the query.
// Reset clears valid bits, loads THRESHOLD_RESET; the result strobe is never held off.
module segment_sphere_occlusion_sum
   import ssos_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ssos_req_type req_data,
   output logic         rsp_strobe,
   output ssos_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SUM_W = 29 + IDX_W;
   localparam logic [8:0] DEPTH_9 = 9'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

   ssos_state_type state_ff, state_in;
   ssos_job_type   job_ff;
   logic [1:0]     lane_ff;

   ssos_req_type            req_ff;
   logic [15:0]             thr_ff;
   logic [TABLE_DEPTH-1:0]  valid_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic                    rsp_strobe_ff;
   ssos_rsp_type            rsp_data_ff;

   logic [33:0]        l2_ff, fsq_ff, tsq_ff;
   logic signed [34:0] dt_ff, dv_ff;
   logic [23:0]        rb_ff;
   logic [47:0]        r2_ff;
   logic [24:0]        slen_ff, offf_ff, offt_ff, half_ff;
   logic [49:0]        q1_ff, q2_ff, ls_ff;
   logic [SUM_W-1:0]   sum_ff;

   ssos_acmd_type  acmd;
   ssos_ares_type  ares;
   ssos_entry_type ent, wr_ent;

   logic                 ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [$bits(ssos_entry_type)-1:0] ram_rd_data;

   logic              accept, in_slot_ok, req_slot_valid, last_entry;
   logic              rsp_strobe_in;
   logic [8:0]        in_slot_9, req_slot_9;
   logic [IDX_W-1:0]  in_addr, req_addr;

   logic signed [15:0] a_v [3];
   logic signed [15:0] b_v [3];
   logic signed [15:0] c_v [3];
   logic signed [16:0] d_v [3];
   logic signed [16:0] t_v [3];
   logic signed [16:0] v_v [3];

   logic [49:0] fsq16, tsq16, r2_50;
   logic        dt_neg, dt_ge_l2, dt_pos, dv_pos, f_in, t_in, ls_ge_r2;
   logic [25:0] contrib;

   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   assign in_slot_9  = {5'd0, req_data.slot};
   assign req_slot_9 = {5'd0, req_ff.slot};
   assign in_addr    = in_slot_9[IDX_W-1:0];
   assign req_addr   = req_slot_9[IDX_W-1:0];
   assign in_slot_ok = in_slot_9 < DEPTH_9;
   assign req_slot_valid = in_slot_ok && valid_ff[in_addr];
   assign last_entry = idx_ff == IDX_LAST;

   // non-queries answer at once, except a set radius that needs write back
   assign rsp_strobe_in = (state_ff == S_SETR) || (state_ff == S_DONE) ||
                          (state_ff == S_IDLE && accept &&
                           req_data.operation != OP_QUERY &&
                           !(req_data.operation == OP_SET_RADIUS && req_slot_valid));

   assign ent = ram_rd_data;

   always_comb begin
      a_v[0] = req_ff.ax; a_v[1] = req_ff.ay; a_v[2] = req_ff.az;
      b_v[0] = req_ff.bx; b_v[1] = req_ff.by; b_v[2] = req_ff.bz;
      c_v[0] = ent.cx;    c_v[1] = ent.cy;    c_v[2] = ent.cz;
      for (int k = 0; k < 3; k++) begin
         d_v[k] = 17'(b_v[k]) - 17'(a_v[k]);
         t_v[k] = 17'(c_v[k]) - 17'(a_v[k]);
         v_v[k] = 17'(b_v[k]) - 17'(c_v[k]);
      end
   end

   assign fsq16    = {fsq_ff, 16'd0};
   assign tsq16    = {tsq_ff, 16'd0};
   assign r2_50    = {2'd0, r2_ff};
   assign dt_neg   = dt_ff[34];
   assign dt_ge_l2 = !dt_ff[34] && (dt_ff[33:0] >= l2_ff);
   assign dt_pos   = !dt_ff[34] && (dt_ff != '0);
   assign dv_pos   = !dv_ff[34] && (dv_ff != '0);
   assign f_in     = fsq16 < r2_50;
   assign t_in     = tsq16 < r2_50;
   assign ls_ge_r2 = ls_ff >= r2_50;

   always_comb begin
      if (f_in && t_in) begin
         contrib = {1'b0, slen_ff};
      end else if (f_in) begin
         contrib = dt_pos ? {1'b0, half_ff} + {1'b0, offf_ff} : {1'b0, half_ff};
      end else if (t_in) begin
         contrib = dv_pos ? {1'b0, half_ff} + {1'b0, offt_ff} : {1'b0, half_ff};
      end else begin
         contrib = {half_ff, 1'b0};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  OP_QUERY:      state_in = S_GO;
                  OP_SET_RADIUS: if (req_slot_valid) state_in = S_SETR;
                  default:       state_in = S_IDLE;
               endcase
            end
         end
         S_SETR: state_in = S_IDLE;
         S_GO:   state_in = S_WAIT;
         S_WAIT: begin
            if (ares.done) begin
               unique case (job_ff)
                  J_SLEN:  state_in = S_ENT_RD;
                  J_R2:    state_in = S_CLASS;
                  J_OFFT:  state_in = S_CHECK;
                  J_HALF:  state_in = S_ADD;
                  default: state_in = S_GO;
               endcase
            end
         end
         S_ENT_RD: begin
            if (valid_ff[idx_ff]) state_in = S_ENT_LATCH;
            else if (last_entry)  state_in = S_DONE;
         end
         S_ENT_LATCH: begin
            if (ent.smoke)       state_in = S_GO;
            else if (last_entry) state_in = S_DONE;
            else                 state_in = S_ENT_RD;
         end
         S_CLASS: state_in = (dt_neg || dt_ge_l2) ? S_CHECK : S_GO;
         S_CHECK: begin
            if (!ls_ge_r2)       state_in = S_GO;
            else if (last_entry) state_in = S_DONE;
            else                 state_in = S_ENT_RD;
         end
         S_ADD:  state_in = last_entry ? S_DONE : S_ENT_RD;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy        = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = in_addr;
      wr_ent      = '{smoke: req_data.is_smoke, cx: req_data.ax, cy: req_data.ay,
                      cz: req_data.az, radius: req_data.radius};
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;
      acmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            busy        = 1'b0;
            ram_rd_addr = in_addr;
            if (accept && in_slot_ok) begin
               ram_wr_en = req_data.operation == OP_INSERT;
               ram_rd_en = req_data.operation == OP_SET_RADIUS;
            end
         end
         S_SETR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = req_addr;
            wr_ent      = ent;
            wr_ent.radius = req_ff.radius;
         end
         S_GO: begin
            acmd.start = 1'b1;
            acmd.op    = AOP_MUL;
            unique case (job_ff)
               J_L2:  begin acmd.ma = 25'(d_v[lane_ff]); acmd.mb = 25'(d_v[lane_ff]); end
               J_FSQ: begin acmd.ma = 25'(t_v[lane_ff]); acmd.mb = 25'(t_v[lane_ff]); end
               J_TSQ: begin acmd.ma = 25'(v_v[lane_ff]); acmd.mb = 25'(v_v[lane_ff]); end
               J_DT:  begin acmd.ma = 25'(t_v[lane_ff]); acmd.mb = 25'(d_v[lane_ff]); end
               J_DV:  begin acmd.ma = 25'(v_v[lane_ff]); acmd.mb = 25'(d_v[lane_ff]); end
               J_RB: begin
                  acmd.ma = $signed({13'd0, ent.radius});
                  acmd.mb = $signed({13'd0, req_ff.bloat});
               end
               J_R2: begin
                  acmd.ma = $signed({1'b0, rb_ff});
                  acmd.mb = $signed({1'b0, rb_ff});
               end
               J_SLEN: begin acmd.op = AOP_SQRT; acmd.rad = {l2_ff, 16'd0}; end
               J_Q1: begin
                  acmd.op  = AOP_PROJ;
                  acmd.num = dt_ff[33:0];
                  acmd.den = l2_ff;
               end
               J_Q2: begin
                  acmd.op  = AOP_PROJ;
                  acmd.num = l2_ff - dt_ff[33:0];
                  acmd.den = l2_ff;
               end
               J_OFFF: begin acmd.op = AOP_SQRT; acmd.rad = q1_ff; end
               J_OFFT: begin acmd.op = AOP_SQRT; acmd.rad = q2_ff; end
               J_HALF: begin acmd.op = AOP_SQRT; acmd.rad = r2_50 - ls_ff; end
               default: ;
            endcase
         end
         S_ENT_RD: ram_rd_en = valid_ff[idx_ff];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         thr_ff        <= THRESHOLD_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_data;
         end
         if (state_ff == S_IDLE && accept) begin
            if (in_slot_ok && req_data.operation == OP_INSERT) valid_ff[in_addr] <= 1'b1;
            if (in_slot_ok && req_data.operation == OP_REMOVE) valid_ff[in_addr] <= 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            rsp_data_ff <= '0;
            if (accept) begin
               req_ff  <= req_data;
               job_ff  <= J_L2;
               lane_ff <= '0;
               l2_ff   <= '0;
               sum_ff  <= '0;
               idx_ff  <= '0;
            end
         end
         S_WAIT: begin
            if (ares.done) begin
               unique case (job_ff)
                  J_L2, J_FSQ, J_TSQ, J_DT, J_DV: begin
                     lane_ff <= (lane_ff == LANE_LAST) ? 2'd0 : lane_ff + 2'd1;
                     unique case (job_ff)
                        J_L2:  l2_ff  <= l2_ff  + ares.value[33:0];
                        J_FSQ: fsq_ff <= fsq_ff + ares.value[33:0];
                        J_TSQ: tsq_ff <= tsq_ff + ares.value[33:0];
                        J_DT:  dt_ff  <= dt_ff  + $signed(ares.value[34:0]);
                        default: dv_ff <= dv_ff + $signed(ares.value[34:0]);
                     endcase
                     if (lane_ff == LANE_LAST) begin
                        unique case (job_ff)
                           J_L2:    job_ff <= J_SLEN;
                           J_FSQ:   job_ff <= J_TSQ;
                           J_TSQ:   job_ff <= J_DT;
                           J_DT:    job_ff <= J_DV;
                           default: job_ff <= J_RB;
                        endcase
                     end
                  end
                  J_RB: begin
                     rb_ff  <= ares.value[23:0];
                     job_ff <= J_R2;
                  end
                  J_R2:   r2_ff   <= ares.value[47:0];
                  J_SLEN: slen_ff <= ares.value[24:0];
                  J_Q1: begin
                     q1_ff  <= ares.value;
                     ls_ff  <= (ares.value > fsq16) ? 50'd0 : fsq16 - ares.value;
                     job_ff <= J_Q2;
                  end
                  J_Q2: begin
                     q2_ff  <= ares.value;
                     job_ff <= J_OFFF;
                  end
                  J_OFFF: begin
                     offf_ff <= ares.value[24:0];
                     job_ff  <= J_OFFT;
                  end
                  J_OFFT: offt_ff <= ares.value[24:0];
                  J_HALF: half_ff <= ares.value[24:0];
                  default: ;
               endcase
            end
         end
         S_ENT_RD: begin
            if (!valid_ff[idx_ff] && !last_entry) idx_ff <= idx_ff + IDX_ONE;
         end
         S_ENT_LATCH: begin
            if (ent.smoke) begin
               job_ff  <= J_FSQ;
               lane_ff <= '0;
               fsq_ff  <= '0;
               tsq_ff  <= '0;
               dt_ff   <= '0;
               dv_ff   <= '0;
            end else if (!last_entry) begin
               idx_ff <= idx_ff + IDX_ONE;
            end
         end
         S_CLASS: begin
            if (dt_neg) begin
               ls_ff   <= fsq16;
               offf_ff <= '0;
               offt_ff <= slen_ff;
            end else if (dt_ge_l2) begin
               ls_ff   <= tsq16;
               offf_ff <= slen_ff;
               offt_ff <= '0;
            end else begin
               job_ff <= J_Q1;
            end
         end
         S_CHECK: begin
            if (!ls_ge_r2)        job_ff <= J_HALF;
            else if (!last_entry) idx_ff <= idx_ff + IDX_ONE;
         end
         S_ADD: begin
            sum_ff <= sum_ff + SUM_W'(contrib);
            if (!last_entry) idx_ff <= idx_ff + IDX_ONE;
         end
         S_DONE: begin
            rsp_data_ff.blocked <= sum_ff > SUM_W'({thr_ff, 8'd0});
            rsp_data_ff.covered_length <= (|sum_ff[SUM_W-1:28]) ? 20'hFFFFF
                                                                 : sum_ff[27:8];
         end
         default: ;
      endcase
   end

   ssos_ram #(
      .WIDTH($bits(ssos_entry_type)),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(wr_ent),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   ssos_arith u_arith (
      .clock(clock),
      .reset(reset),
      .cmd  (acmd),
      .res  (ares)
   );

endmodule

/* test/testbench.sv */
// Self-checking bench for segment_sphere_occlusion_sum: random sphere-table
// traffic and segment queries checked against an in-bench occlusion predictor.
// Depends on ssos_pkg and the RTL of the block.
module testbench;
   import ssos_pkg::*;

   localparam int DEPTH = 16;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam longint unsigned SUM_SAT = 64'd1048575;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   ssos_req_type req_data = '0;
   logic         rsp_strobe;
   ssos_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data = '0;

   segment_sphere_occlusion_sum dut (.*);

   always #5 clock = ~clock;

   // shadow of the sphere table and threshold
   logic            tab_valid [DEPTH];
   logic            tab_smoke [DEPTH];
   longint          tab_center [DEPTH][3];
   longint unsigned tab_radius [DEPTH];
   longint unsigned threshold = 64'd108;

   ssos_req_type pending_items [$];
   ssos_rsp_type expected_rsp [$];
   int  send_idle_pct = 0;
   bit  taken = 1'b0;
   int  errors = 0;
   int  quiet_cycles = 0;

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else
            res >>= 1;
         bitv >>= 2;
      end
      return res;
   endfunction

   // floor(n^2 * 2^16 / d)
   function automatic longint unsigned proj_q16(longint unsigned n, longint unsigned d);
      logic [127:0] num;
      logic [127:0] quo;
      num = ({64'd0, n} * {64'd0, n}) << 16;
      quo = num / {64'd0, d};
      return quo[63:0];
   endfunction

   // Q.8 length of segment a->b inside bloated sphere e
   function automatic longint unsigned covered_q8(int e, longint a[3], longint b[3],
                                                  longint unsigned bloat);
      longint d[3], t[3], v[3];
      longint dt, dv;
      longint unsigned l2, r2, ls, fsq, tsq, half, slen, offf, offt, rb, q;
      for (int k = 0; k < 3; k++) begin
         d[k] = b[k] - a[k];
         t[k] = tab_center[e][k] - a[k];
         v[k] = b[k] - tab_center[e][k];
      end
      rb = tab_radius[e] * bloat;
      r2 = rb * rb;
      l2 = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      dt = t[0]*d[0] + t[1]*d[1] + t[2]*d[2];
      dv = v[0]*d[0] + v[1]*d[1] + v[2]*d[2];
      fsq = longint'(t[0]*t[0] + t[1]*t[1] + t[2]*t[2]) << 16;
      tsq = longint'(v[0]*v[0] + v[1]*v[1] + v[2]*v[2]) << 16;
      slen = isqrt(l2 << 16);
      if (dt < 0) begin
         ls = fsq; offf = 0; offt = slen;
      end else if (longint'(unsigned'(dt)) >= 0 && dt >= l2) begin
         ls = tsq; offf = slen; offt = 0;
      end else begin
         q = proj_q16(dt, l2);
         ls = (q > fsq) ? 0 : fsq - q;
         offf = isqrt(q);
         offt = isqrt(proj_q16(l2 - dt, l2));
      end
      if (ls >= r2) return 0;
      half = isqrt(r2 - ls);
      if (fsq < r2) begin
         if (tsq < r2) return slen;
         return (dt > 0) ? half + offf : half;
      end
      if (tsq < r2) return (dv > 0) ? half + offt : half;
      return half << 1;
   endfunction

   function automatic ssos_rsp_type apply_item(ssos_req_type it);
      ssos_rsp_type r;
      longint a[3], b[3];
      longint unsigned sum, ip;
      r = '0;
      case (it.operation)
         OP_QUERY: begin
            a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
            b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
            sum = 0;
            for (int e = 0; e < DEPTH; e++)
               if (tab_valid[e] && tab_smoke[e]) sum += covered_q8(e, a, b, it.bloat);
            ip = sum >> 8;
            r.blocked = (sum > (threshold << 8));
            r.covered_length = (ip > SUM_SAT) ? SUM_SAT[19:0] : ip[19:0];
         end
         OP_INSERT: begin
            tab_valid[it.slot] = 1'b1;
            tab_smoke[it.slot] = it.is_smoke;
            tab_center[it.slot][0] = it.ax;
            tab_center[it.slot][1] = it.ay;
            tab_center[it.slot][2] = it.az;
            tab_radius[it.slot] = it.radius;
         end
         OP_REMOVE: tab_valid[it.slot] = 1'b0;
         OP_SET_RADIUS: if (tab_valid[it.slot]) tab_radius[it.slot] = it.radius;
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] coord(int spread);
      if (spread == 0) return 16'($urandom);
      return 16'($urandom_range(2 * spread) - spread);
   endfunction

   function automatic ssos_req_type make_item(ssos_op_type op, int spread);
      ssos_req_type it;
      it = ssos_req_type'({$urandom, $urandom, $urandom, $urandom});
      it.operation = op;
      if (spread != 0) begin
         it.ax = coord(spread); it.ay = coord(spread); it.az = coord(spread);
         it.bx = coord(spread); it.by = coord(spread); it.bz = coord(spread);
         if ($urandom_range(3) == 0) it.radius = 12'($urandom_range(spread));
         if ($urandom_range(2) != 0) it.bloat = 12'($urandom_range(128, 512));
      end
      return it;
   endfunction

   function automatic ssos_req_type random_item();
      int pick, spread;
      pick = $urandom_range(99);
      case ($urandom_range(9))
         0: spread = 0;
         1, 2: spread = 30000;
         default: spread = 3000;
      endcase
      if (pick < 30) return make_item(OP_INSERT, spread);
      if (pick < 55) return make_item(OP_REMOVE, spread);
      if (pick < 70) return make_item(OP_SET_RADIUS, spread);
      return make_item(OP_QUERY, spread);
   endfunction

   function automatic ssos_req_type pick_item(ssos_op_type op, logic [3:0] slot,
                                              int cx, int cy, int cz,
                                              int ex, int ey, int ez,
                                              int rad, logic smoke, int bloat);
      ssos_req_type it;
      it = '0;
      it.operation = op; it.slot = slot;
      it.ax = 16'(cx); it.ay = 16'(cy); it.az = 16'(cz);
      it.bx = 16'(ex); it.by = 16'(ey); it.bz = 16'(ez);
      it.radius = 12'(rad); it.is_smoke = smoke; it.bloat = 12'(bloat);
      return it;
   endfunction

   // accept side: prediction, result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || (csr_valid && csr_ready) || rsp_strobe)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (start && !busy) begin
            expected_rsp.push_back(apply_item(req_data));
            taken = 1'b1;
         end
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result beat: blocked=%0d covered_length=%0d",
                      rsp_data.blocked, rsp_data.covered_length);
               errors++;
            end else begin
               ssos_rsp_type exp_r;
               exp_r = expected_rsp.pop_front();
               if (rsp_data.blocked !== exp_r.blocked) begin
                  $error("blocked: expected %0d actual %0d", exp_r.blocked, rsp_data.blocked);
                  errors++;
               end
               if (rsp_data.covered_length !== exp_r.covered_length) begin
                  $error("covered_length: expected %0d actual %0d",
                         exp_r.covered_length, rsp_data.covered_length);
                  errors++;
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL segment_sphere_occlusion_sum");
            $finish;
         end
      end
   end

   // driver: new beat on the falling edge once the last one was taken
   always @(negedge clock) begin
      if (reset)
         start <= 1'b0;
      else if (!start || taken) begin
         taken = 1'b0;
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_items.pop_front();
            start <= 1'b1;
         end else
            start <= 1'b0;
      end
   end

   task automatic write_threshold(logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      threshold = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // waits until every queued item is sent and every expected result is back
   task automatic drain();
      while (pending_items.size() > 0 || start || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_random(int count, int idle_pct);
      send_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) pending_items.push_back(random_item());
      drain();
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         tab_valid[i] = 1'b0; tab_smoke[i] = 1'b0; tab_radius[i] = 0;
         for (int k = 0; k < 3; k++) tab_center[i][k] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_threshold(16'd0);

      // extremes and each coverage case
      pending_items.push_back(pick_item(OP_QUERY, 0, 0, 0, 0, 100, 0, 0, 0, 0, 256));
      pending_items.push_back(pick_item(OP_INSERT, 0, 0, 0, 0, 0, 0, 0, 100, 1, 0));
      pending_items.push_back(pick_item(OP_INSERT, 15, -32768, -32768, -32768, 0, 0, 0,
                                        4095, 0, 0));
      pending_items.push_back(pick_item(OP_QUERY, 0, -50, 0, 0, 50, 0, 0, 0, 0, 256));
      pending_items.push_back(pick_item(OP_QUERY, 0, -500, 0, 0, 30, 0, 0, 0, 0, 256));
      pending_items.push_back(pick_item(OP_QUERY, 0, -500, 0, 0, 500, 0, 0, 0, 0, 256));
      pending_items.push_back(pick_item(OP_QUERY, 0, 500, 30, 0, -20, 0, 0, 0, 0, 256));
      pending_items.push_back(pick_item(OP_QUERY, 0, 40, 0, 0, 300, 0, 0, 0, 0, 256));
      pending_items.push_back(pick_item(OP_QUERY, 0, 10, 10, 10, 10, 10, 10, 0, 0, 256));
      pending_items.push_back(pick_item(OP_QUERY, 0, -32768, -32768, -32768,
                                        32767, 32767, 32767, 0, 0, 4095));
      pending_items.push_back(pick_item(OP_QUERY, 0, -500, 0, 0, 500, 0, 0, 0, 0, 0));
      pending_items.push_back(pick_item(OP_SET_RADIUS, 0, 0, 0, 0, 0, 0, 0, 4095, 0, 0));
      pending_items.push_back(pick_item(OP_SET_RADIUS, 7, 0, 0, 0, 0, 0, 0, 50, 0, 0));
      pending_items.push_back(pick_item(OP_REMOVE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(pick_item(OP_INSERT, 0, 32767, 32767, 32767, 0, 0, 0,
                                        4095, 1, 0));
      pending_items.push_back(pick_item(OP_INSERT, 1, -32768, -32768, -32768, 0, 0, 0,
                                        4095, 1, 0));
      pending_items.push_back(pick_item(OP_QUERY, 0, -32768, -32768, -32768,
                                        32767, 32767, 32767, 0, 0, 4095));
      pending_items.push_back(pick_item(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(pick_item(OP_QUERY, 0, -32768, -32768, -32768,
                                        32767, 32767, 32767, 0, 0, 4095));
      pending_items.push_back(pick_item(OP_REMOVE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drain();

      write_threshold(16'hFFFF);
      run_random(630, 19);
      write_threshold(16'($urandom));
      run_random(630, 77);
      write_threshold(16'd108);
      run_random(640, 0);

      if (errors == 0)
         $display("PASS segment_sphere_occlusion_sum");
      else
         $display("FAIL segment_sphere_occlusion_sum");
      $finish;
   end

endmodule
